>>> rtl/core/mrp_pkg.sv
// ----------------------------------------------------------------------------
// mrp_pkg
// Shared constants for the Miller-Rabin primality block.
// ----------------------------------------------------------------------------
package mrp_pkg;
  localparam int unsigned MaxBases = 12;
  localparam int unsigned BaseW = 6;

  function automatic logic [BaseW-1:0] base_at(input logic [3:0] k);
    logic [BaseW-1:0] b;
    case (k)
      4'd0: b = 6'd2;
      4'd1: b = 6'd3;
      4'd2: b = 6'd5;
      4'd3: b = 6'd7;
      4'd4: b = 6'd11;
      4'd5: b = 6'd13;
      4'd6: b = 6'd17;
      4'd7: b = 6'd19;
      4'd8: b = 6'd23;
      4'd9: b = 6'd29;
      4'd10: b = 6'd31;
      4'd11: b = 6'd37;
      default: b = 6'd37;
    endcase
    return b;
  endfunction
endpackage

>>> rtl/core/mrp_stream_if.sv
// ----------------------------------------------------------------------------
// mrp_stream_if
// Valid/ready channel carrying one payload.
// ----------------------------------------------------------------------------
interface mrp_stream_if #(
  parameter int unsigned W = 1
);
  logic         valid;
  logic         ready;
  logic [W-1:0] data;
  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

>>> rtl/core/miller_rabin_primality_64.sv
// ----------------------------------------------------------------------------
// miller_rabin_primality_64
// Deterministic Miller-Rabin test over the first NUM_BASES primes.
// ----------------------------------------------------------------------------
// channel   dir  payload
// cand      in   candidate [NUM_WIDTH-1:0]
// res       out  is_prime [0]
//
// Each modular product is issued from one state, then the multiplier steps
// through its NUM_WIDTH multiplier bits and raises a registered done. A base
// needs up to about 2*NUM_WIDTH products. Trivial candidates (below 4 or
// even) go straight to DONE without a base test. Reset returns to idle. Hold
// a finished result in the output register; a second result waits in DONE
// and blocks the next item until the sink drains.
module miller_rabin_primality_64 #(
  parameter int unsigned NUM_WIDTH = 64,
  parameter int unsigned NUM_BASES = 12
) (
  input  logic       clk_i,
  input  logic       rst_ni,
  mrp_stream_if.sink   cand,
  mrp_stream_if.source res
);
  import mrp_pkg::*;
  localparam int unsigned W = NUM_WIDTH;
  localparam int unsigned SW = $clog2(W + 1);
  localparam logic [3:0] LastBase = 4'(((NUM_BASES > MaxBases) ? MaxBases : NUM_BASES) - 1);

  typedef enum logic [3:0] {
    IDLE, SPLIT, BASE, PSTEP, PWAIT_A, PSQ, PWAIT_B, CHECK, SQ, SQ_WAIT, NEXT, DONE
  } state_e;

  state_e         st_q;
  logic [W-1:0]   n_q, nm1_q, d_q, e_q, acc_q, b_q, x_q;
  logic [SW-1:0]  s_q, r_q;
  logic [3:0]     k_q;
  logic           res_q;
  logic           ov_q, od_q;
  logic           mstart;
  logic [W-1:0]   ma, mb, mr;
  logic           mdone;
  logic [W-1:0]   base_w;

  assign base_w = W'(base_at(k_q));

  mrp_mulmod #(.W(W)) u_mul (
    .clk_i, .rst_ni, .start_i(mstart), .a_i(ma), .b_i(mb), .m_i(n_q),
    .done_o(mdone), .r_o(mr)
  );

  always_comb begin
    mstart = 1'b0;
    ma = b_q;
    mb = b_q;
    case (st_q)
      PSTEP: begin
        mstart = 1'b1;
        ma = b_q;
        mb = e_q[0] ? acc_q : b_q;
      end
      PSQ: mstart = 1'b1;
      SQ: begin
        mstart = 1'b1;
        ma = x_q;
        mb = x_q;
      end
      default: ;
    endcase
  end

  assign cand.ready = (st_q == IDLE);
  assign res.valid = ov_q;
  assign res.data = od_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      st_q <= IDLE;
      res_q <= 1'b0;
      ov_q <= 1'b0;
      od_q <= 1'b0;
      k_q <= '0;
      s_q <= '0;
      r_q <= '0;
    end else begin
      case (st_q)
        IDLE: if (cand.valid) begin
          n_q <= cand.data;
          nm1_q <= cand.data - 1'b1;
          d_q <= cand.data - 1'b1;
          s_q <= '0;
          k_q <= '0;
          if (cand.data < W'(2)) begin
            res_q <= 1'b0;
            st_q <= DONE;
          end else if (cand.data == W'(2) || cand.data == W'(3)) begin
            res_q <= 1'b1;
            st_q <= DONE;
          end else if (!cand.data[0]) begin
            res_q <= 1'b0;
            st_q <= DONE;
          end else begin
            st_q <= SPLIT;
          end
        end
        SPLIT: begin
          if (!d_q[0]) begin
            d_q <= d_q >> 1;
            s_q <= s_q + 1'b1;
          end else begin
            st_q <= BASE;
          end
        end
        BASE: begin
          if (n_q <= base_w) begin
            res_q <= 1'b1;
            st_q <= DONE;
          end else begin
            acc_q <= W'(1);
            b_q <= base_w;
            e_q <= d_q;
            st_q <= (d_q == '0) ? CHECK : PSTEP;
          end
        end
        PSTEP: st_q <= PWAIT_A;
        PWAIT_A: if (mdone) begin
          if (e_q[0]) begin
            acc_q <= mr;
          end
          st_q <= PSQ;
        end
        PSQ: st_q <= PWAIT_B;
        PWAIT_B: if (mdone) begin
          b_q <= mr;
          e_q <= e_q >> 1;
          st_q <= ((e_q >> 1) == '0) ? CHECK : PSTEP;
        end
        CHECK: begin
          x_q <= acc_q;
          r_q <= SW'(1);
          st_q <= (acc_q == W'(1) || acc_q == nm1_q) ? NEXT : SQ;
        end
        SQ: begin
          if (r_q >= s_q) begin
            res_q <= 1'b0;
            st_q <= DONE;
          end else begin
            st_q <= SQ_WAIT;
          end
        end
        SQ_WAIT: if (mdone) begin
          x_q <= mr;
          r_q <= r_q + 1'b1;
          st_q <= (mr == nm1_q) ? NEXT : SQ;
        end
        NEXT: begin
          if (k_q == LastBase) begin
            res_q <= 1'b1;
            st_q <= DONE;
          end else begin
            k_q <= k_q + 1'b1;
            st_q <= BASE;
          end
        end
        DONE: if (!ov_q || res.ready) st_q <= IDLE;
        default: st_q <= IDLE;
      endcase
      if (st_q == DONE && (!ov_q || res.ready)) begin
        ov_q <= 1'b1;
        od_q <= res_q;
      end else if (res.ready) begin
        ov_q <= 1'b0;
      end
    end
  end
endmodule

>>> rtl/core/mrp_mulmod.sv
// ----------------------------------------------------------------------------
// mrp_mulmod
// Bit-serial modular multiplier: one multiplier bit per cycle, MSB first.
// ----------------------------------------------------------------------------
module mrp_mulmod #(
  parameter int unsigned W = 64
) (
  input  logic         clk_i,
  input  logic         rst_ni,
  input  logic         start_i,
  input  logic [W-1:0] a_i,
  input  logic [W-1:0] b_i,
  input  logic [W-1:0] m_i,
  output logic         done_o,
  output logic [W-1:0] r_o
);
  localparam int unsigned CW = $clog2(W);

  logic [W-1:0]  r_q, r_d, b_q, b_d, a_q, a_d;
  logic [CW-1:0] cnt_q, cnt_d;
  logic          busy_q, busy_d, done_q, done_d;
  logic [W:0]    s1, s2;
  logic [W-1:0]  t1;

  always_comb begin
    s1 = {1'b0, r_q} + {1'b0, r_q};
    t1 = (s1 >= {1'b0, m_i}) ? W'(s1 - {1'b0, m_i}) : s1[W-1:0];
    s2 = {1'b0, t1} + {1'b0, a_q};
    r_d = r_q;
    b_d = b_q;
    a_d = a_q;
    cnt_d = cnt_q;
    busy_d = busy_q;
    done_d = 1'b0;
    if (start_i) begin
      r_d = '0;
      b_d = b_i;
      a_d = a_i;
      cnt_d = '0;
      busy_d = 1'b1;
    end else if (busy_q) begin
      if (b_q[W-1]) begin
        r_d = (s2 >= {1'b0, m_i}) ? W'(s2 - {1'b0, m_i}) : s2[W-1:0];
      end else begin
        r_d = t1;
      end
      b_d = {b_q[W-2:0], 1'b0};
      cnt_d = cnt_q + 1'b1;
      if (cnt_q == CW'(W - 1)) begin
        busy_d = 1'b0;
        done_d = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q <= '0;
    end else begin
      busy_q <= busy_d;
      done_q <= done_d;
      cnt_q <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    r_q <= r_d;
    b_q <= b_d;
    a_q <= a_d;
  end

  assign done_o = done_q;
  assign r_o = r_q;
endmodule

>>> rtl/core/mrp_checker.sv
// ----------------------------------------------------------------------------
// mrp_checker
// Port-level checks for the primality block.
// ----------------------------------------------------------------------------
module mrp_checker (
  input logic clk_i,
  input logic rst_ni,
  input logic in_valid_i,
  input logic in_ready_i,
  input logic out_valid_i,
  input logic out_ready_i,
  input logic out_data_i
);
  a_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && in_ready_i |=> !in_ready_i) else $error("ready after accept");
  a_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && !out_ready_i |=> out_valid_i && $stable(out_data_i))
    else $error("result dropped");
  a_known: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i |-> !$isunknown(out_data_i)) else $error("unknown result");
  a_ready_known: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !$isunknown(in_ready_i) && !$isunknown(out_valid_i))
    else $error("unknown handshake");
endmodule

bind miller_rabin_primality_64 mrp_checker u_chk (
  .clk_i, .rst_ni, .in_valid_i(cand.valid), .in_ready_i(cand.ready),
  .out_valid_i(res.valid), .out_ready_i(res.ready), .out_data_i(res.data)
);

>>> bench/mrp_tb_if.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// mrp_tb_if
// Bench package with the candidate width; the stream interface comes from the RTL folder.
// ----------------------------------------------------------------------------
// The block's channels use mrp_stream_if from the RTL, instanced in the top.
package mrp_tb_pkg;
  localparam int unsigned CandW = 64;
endpackage

>>> bench/miller_rabin_primality_64_tb.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// miller_rabin_primality_64_tb
// Self-checking bench for the 64-bit deterministic Miller-Rabin block.
// Sends candidates over the valid/ready input, predicts each verdict with a
// 128-bit modular arithmetic model, and checks results in order under random
// idling on both sides, a long receiver stall and a full drain pause.
// ----------------------------------------------------------------------------
module miller_rabin_primality_64_tb;
  import mrp_tb_pkg::*;

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;

  mrp_stream_if #(.W(CandW)) cand ();
  mrp_stream_if #(.W(1))     res ();

  miller_rabin_primality_64 #(.NUM_WIDTH(64), .NUM_BASES(12)) u_dut (
    .clk_i (clk_i),
    .rst_ni(rst_ni),
    .cand  (cand),
    .res   (res)
  );

  always #5 clk_i = ~clk_i;

  bit          pending_verdicts[$];
  int unsigned mismatches = 0;
  int unsigned send_idle_pct = 0;
  int unsigned recv_idle_pct = 0;
  int unsigned hold_req_len = 0;
  int unsigned hold_req_id = 0;
  int unsigned hold_seen_id = 0;
  int unsigned hold_left = 0;

  localparam logic [7:0] Witnesses[12] = '{8'd2, 8'd3, 8'd5, 8'd7, 8'd11, 8'd13,
                                           8'd17, 8'd19, 8'd23, 8'd29, 8'd31, 8'd37};

  function automatic logic [63:0] mod_mul(logic [63:0] a, logic [63:0] b, logic [63:0] m);
    logic [127:0] p;
    p = {64'd0, a} * {64'd0, b};
    p = p % {64'd0, m};
    return p[63:0];
  endfunction

  function automatic logic [63:0] mod_pow(logic [63:0] a, logic [63:0] e, logic [63:0] m);
    logic [63:0] acc;
    logic [63:0] sq;
    acc = 64'd1;
    sq  = a % m;
    while (e != 64'd0) begin
      if (e[0]) acc = mod_mul(acc, sq, m);
      sq = mod_mul(sq, sq, m);
      e  = e >> 1;
    end
    return acc;
  endfunction

  function automatic bit predict_prime(logic [63:0] n);
    logic [63:0] nm1;
    logic [63:0] d;
    logic [63:0] x;
    int          s;
    bit          hit;
    if (n < 64'd2) return 1'b0;
    if (n == 64'd2 || n == 64'd3) return 1'b1;
    if (!n[0]) return 1'b0;
    nm1 = n - 64'd1;
    d   = nm1;
    s   = 0;
    while (!d[0]) begin
      d = d >> 1;
      s++;
    end
    for (int k = 0; k < 12; k++) begin
      if (n <= {56'd0, Witnesses[k]}) break;
      x = mod_pow({56'd0, Witnesses[k]}, d, n);
      if (x == 64'd1 || x == nm1) continue;
      hit = 1'b0;
      for (int r = 1; r < s; r++) begin
        x = mod_mul(x, x, n);
        if (x == nm1) begin
          hit = 1'b1;
          break;
        end
      end
      if (!hit) return 1'b0;
    end
    return 1'b1;
  endfunction

  task automatic send_candidate(input logic [63:0] value);
    if ($urandom_range(99) < send_idle_pct) begin
      cand.valid <= 1'b0;
      do @(posedge clk_i); while ($urandom_range(99) < send_idle_pct);
    end
    cand.valid <= 1'b1;
    cand.data  <= value;
    do @(posedge clk_i); while (!cand.ready);
    pending_verdicts = {pending_verdicts, predict_prime(value)};
  endtask

  task automatic stop_sending();
    cand.valid <= 1'b0;
    @(posedge clk_i);
  endtask

  task automatic wait_drain();
    stop_sending();
    while (pending_verdicts.size() != 0) @(posedge clk_i);
  endtask

  // Hold-off counter for long receiver stalls.
  always @(posedge clk_i) begin
    if (hold_req_id != hold_seen_id) begin
      hold_seen_id <= hold_req_id;
      hold_left    <= hold_req_len;
    end else if (hold_left != 0) begin
      hold_left <= hold_left - 1;
    end
  end

  always @(posedge clk_i) begin
    if (rst_ni && res.valid && res.ready) begin
      if (pending_verdicts.size() == 0) begin
        mismatches++;
        if (mismatches <= 10) $display("unexpected result: is_prime=%0b", res.data);
      end else begin
        if (res.data[0] !== pending_verdicts[0]) begin
          mismatches++;
          if (mismatches <= 10)
            $display("mismatch: is_prime expected %0b actual %0b",
                     pending_verdicts[0], res.data);
        end
        void'(pending_verdicts.pop_front());
      end
    end
    res.ready <= (hold_left == 0 && hold_req_id == hold_seen_id) &&
                 ($urandom_range(99) >= recv_idle_pct);
  end

  function automatic logic [63:0] rand_candidate();
    int unsigned pick;
    pick = $urandom_range(99);
    if (pick < 85) return {52'd0, 12'($urandom_range(4095))};
    if (pick < 93) return {32'd0, $urandom};
    return {$urandom, $urandom};
  endfunction

  task automatic test_directed();
    logic [63:0] vals[] = '{64'd0, 64'd1, 64'd2, 64'd3, 64'd4, 64'd5, 64'd9, 64'd25,
                            64'd37, 64'd41, 64'd561, 64'd2047, 64'd1373653,
                            64'd3215031751, 64'd3825123056546413051,
                            64'hFFFF_FFFF_FFFF_FFFF, 64'hFFFF_FFFF_FFFF_FFC5,
                            64'h8000_0000_0000_0000, 64'd4294967291,
                            64'hAAAA_AAAA_AAAA_AAAB, 64'h5555_5555_5555_5555};
    foreach (vals[i]) send_candidate(vals[i]);
    wait_drain();
  endtask

  task automatic test_random(input int unsigned count, input int unsigned s_pct,
                             input int unsigned r_pct);
    send_idle_pct = s_pct;
    recv_idle_pct = r_pct;
    repeat (count) send_candidate(rand_candidate());
    wait_drain();
  endtask

  task automatic test_backpressure();
    send_idle_pct = 0;
    recv_idle_pct = 0;
    hold_req_len  = 3000;
    hold_req_id++;
    repeat (6) send_candidate({56'd0, 7'($urandom_range(127)), 1'b0});
    wait_drain();
  endtask

  task automatic test_drain_pause();
    send_candidate(64'd7919);
    wait_drain();
    send_candidate(64'd7917);
    wait_drain();
  endtask

  initial begin
    cand.valid = 1'b0;
    cand.data  = '0;
    repeat (12) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    test_directed();
    test_random(24, 19, 71);
    test_random(24, 71, 19);
    test_random(25, 0, 0);
    test_backpressure();
    test_drain_pause();
    repeat (200) @(posedge clk_i);
    if (mismatches == 0 && pending_verdicts.size() == 0) begin
      $display("status: pass");
    end else begin
      $display("status: fail");
    end
    $finish;
  end

  initial begin
    #1_000_000_000;
    $display("status: fail");
    $finish;
  end
endmodule

>>> miller_rabin_primality_64.f
rtl/core/mrp_pkg.sv
rtl/core/mrp_stream_if.sv
rtl/core/mrp_mulmod.sv
rtl/core/miller_rabin_primality_64.sv
rtl/core/mrp_checker.sv
bench/mrp_tb_if.sv
bench/miller_rabin_primality_64_tb.sv
